### rtl/ehdct_pkg.sv
// Shared codes, widths and storage word types for the event handle double-close tracker.
package ehdct_pkg;

	localparam int RING_DEPTH_DEF = 256;
	localparam int SLOT_COUNT_DEF = 64;

	localparam int HANDLE_W = 48;
	localparam int SITE_W   = 16;
	localparam int SLOT_W   = 6;

	localparam logic [1:0] CMD_CREATE  = 2'd0;
	localparam logic [1:0] CMD_TRACKED = 2'd1;
	localparam logic [1:0] CMD_CLOSE   = 2'd2;
	localparam logic [1:0] CMD_UNUSED  = 2'd3;

	localparam logic [1:0] ST_OK   = 2'd0;
	localparam logic [1:0] ST_NULL = 2'd1;
	localparam logic [1:0] ST_FULL = 2'd2;
	localparam logic [1:0] ST_DUP  = 2'd3;

	typedef struct packed {
		logic                closed;
		logic [HANDLE_W-1:0] handle;
		logic [SITE_W-1:0]   file;
		logic [SITE_W-1:0]   line;
	} ring_word_t;

	typedef struct packed {
		logic                active;
		logic                timer;
		logic [HANDLE_W-1:0] handle;
	} slot_word_t;

endpackage

### rtl/event_handle_double_close_tracker.sv
// Top level: close ring and tracked-slot table scanned under a small sequencer.
// One command is taken while busy is low; its single result appears on the result ports for
// exactly one cycle with done high and must be captured then, since the block cannot be stalled.
// Both tables sit in single-port-read memories and are swept one entry per cycle by a pipelined
// scan counter. A null handle or unused command goes straight to done without a sweep. A plain
// create sweeps the ring. A close sweeps the ring and then the slot table, stopping early on a
// double close or on the matching slot. A tracked create sweeps the slots up to the first free
// one, then the ring; if no slot is free it finishes with full status instead of the ring sweep.
// No clearing pass is needed after reset: ring entries beyond the write head before the first
// wrap and slots beyond the highest slot ever taken read as empty.
module event_handle_double_close_tracker
	import ehdct_pkg::*;
#(
	parameter int RING_DEPTH = RING_DEPTH_DEF,
	parameter int SLOT_COUNT = SLOT_COUNT_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	output logic                busy,
	input  logic [1:0]          command,
	input  logic [HANDLE_W-1:0] handle,
	input  logic                timer_flag,
	input  logic [SITE_W-1:0]   site_file,
	input  logic [SITE_W-1:0]   site_line,
	output logic                done,
	output logic [1:0]          status,
	output logic [SLOT_W-1:0]   slot_index,
	output logic                cancel_timer,
	output logic                released_tracked,
	output logic [SITE_W-1:0]   first_file,
	output logic [SITE_W-1:0]   first_line
);

	localparam int RAW  = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;
	localparam int SAW  = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
	localparam int HW   = $clog2(SLOT_COUNT + 1);
	localparam int MAXD = (RING_DEPTH > SLOT_COUNT) ? RING_DEPTH : SLOT_COUNT;
	localparam int CW   = $clog2(MAXD + 1);

	localparam logic [1:0] S_IDLE  = 2'd0;
	localparam logic [1:0] S_RSCAN = 2'd1;
	localparam logic [1:0] S_SSCAN = 2'd2;
	localparam logic [1:0] S_DONE  = 2'd3;

	logic [1:0]     state_q;
	logic [CW-1:0]  cnt_q;
	logic           vld_s1;
	logic [CW-1:0]  idx_s1;
	logic [RAW-1:0] head_q;
	logic           wrapped_q;
	logic [HW-1:0]  hw_q;

	logic [1:0]          cmd_q;
	logic [HANDLE_W-1:0] h_q;
	logic                timer_q;
	logic [SITE_W-1:0]   file_q;
	logic [SITE_W-1:0]   line_q;
	logic [1:0]          status_q;
	logic [SAW-1:0]      slot_q;
	logic                cancel_q;
	logic                released_q;
	logic [SITE_W-1:0]   ffile_q;
	logic [SITE_W-1:0]   fline_q;

	ring_word_t ring_mem [RING_DEPTH];
	slot_word_t slot_mem [SLOT_COUNT];
	ring_word_t ring_rd_q;
	slot_word_t slot_rd_q;

	logic           accept;
	logic           issue;
	logic           restart;
	logic           is_close;
	logic           r_hit;
	logic           r_last;
	logic           s_active;
	logic           s_free_hit;
	logic           s_match;
	logic           s_last;
	logic           ring_we;
	logic [RAW-1:0] ring_waddr;
	ring_word_t     ring_wdata;
	logic           slot_we;
	logic [SAW-1:0] slot_waddr;
	slot_word_t     slot_wdata;
	logic [SAW+SLOT_W-1:0] slot_ext;

	assign accept   = start && (state_q == S_IDLE);
	assign busy     = (state_q != S_IDLE);
	assign done     = (state_q == S_DONE);
	assign is_close = (cmd_q == CMD_CLOSE);

	assign issue = ((state_q == S_RSCAN) && (cnt_q < CW'(RING_DEPTH)))
		|| ((state_q == S_SSCAN) && (cnt_q < CW'(SLOT_COUNT)));

	assign r_hit = vld_s1 && (wrapped_q || (idx_s1[RAW-1:0] < head_q))
		&& ring_rd_q.closed && (ring_rd_q.handle == h_q);
	assign r_last = vld_s1 && (idx_s1 == CW'(RING_DEPTH - 1));

	assign s_active   = (idx_s1 < CW'(hw_q)) && slot_rd_q.active;
	assign s_free_hit = vld_s1 && !s_active;
	assign s_match    = vld_s1 && s_active && (slot_rd_q.handle == h_q);
	assign s_last     = vld_s1 && (idx_s1 == CW'(SLOT_COUNT - 1));

	assign restart = accept
		|| ((state_q == S_RSCAN) && is_close && !r_hit && r_last)
		|| ((state_q == S_SSCAN) && !is_close && s_free_hit);

	always_comb begin
		ring_we    = 1'b0;
		ring_waddr = idx_s1[RAW-1:0];
		ring_wdata = '{closed: 1'b0, handle: '0, file: ring_rd_q.file, line: ring_rd_q.line};
		if (state_q == S_RSCAN) begin
			if (!is_close && r_hit) begin
				ring_we = 1'b1;
			end else if (is_close && r_last && !r_hit) begin
				ring_we    = 1'b1;
				ring_waddr = head_q;
				ring_wdata = '{closed: 1'b1, handle: h_q, file: file_q, line: line_q};
			end
		end
	end

	always_comb begin
		slot_we    = 1'b0;
		slot_waddr = idx_s1[SAW-1:0];
		slot_wdata = '{active: 1'b1, timer: timer_q, handle: h_q};
		if (state_q == S_SSCAN) begin
			if (!is_close && s_free_hit) begin
				slot_we = 1'b1;
			end else if (is_close && s_match) begin
				slot_we    = 1'b1;
				slot_wdata = '{active: 1'b0, timer: slot_rd_q.timer, handle: '0};
			end
		end
	end

	always_ff @(posedge clk) begin
		ring_rd_q <= ring_mem[cnt_q[RAW-1:0]];
		if (ring_we) begin
			ring_mem[ring_waddr] <= ring_wdata;
		end
	end

	always_ff @(posedge clk) begin
		slot_rd_q <= slot_mem[cnt_q[SAW-1:0]];
		if (slot_we) begin
			slot_mem[slot_waddr] <= slot_wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			cnt_q     <= '0;
			vld_s1    <= 1'b0;
			idx_s1    <= '0;
			head_q    <= '0;
			wrapped_q <= 1'b0;
			hw_q      <= '0;
		end else begin
			if (restart) begin
				cnt_q  <= '0;
				vld_s1 <= 1'b0;
			end else begin
				if (issue) begin
					cnt_q <= cnt_q + 1'b1;
				end
				vld_s1 <= issue;
			end
			idx_s1 <= cnt_q;
			case (state_q)
				S_IDLE: begin
					if (start) begin
						if (command == CMD_UNUSED || handle == '0) begin
							state_q <= S_DONE;
						end else if (command == CMD_TRACKED) begin
							state_q <= S_SSCAN;
						end else begin
							state_q <= S_RSCAN;
						end
					end
				end
				S_RSCAN: begin
					if (is_close && r_hit) begin
						state_q <= S_DONE;
					end else if (r_last) begin
						if (is_close) begin
							if (head_q == RAW'(RING_DEPTH - 1)) begin
								head_q    <= '0;
								wrapped_q <= 1'b1;
							end else begin
								head_q <= head_q + 1'b1;
							end
							state_q <= S_SSCAN;
						end else begin
							state_q <= S_DONE;
						end
					end
				end
				S_SSCAN: begin
					if (is_close) begin
						if (s_match || s_last) begin
							state_q <= S_DONE;
						end
					end else if (s_free_hit) begin
						if (idx_s1 == CW'(hw_q)) begin
							hw_q <= hw_q + 1'b1;
						end
						state_q <= S_RSCAN;
					end else if (s_last) begin
						state_q <= S_DONE;
					end
				end
				S_DONE: begin
					state_q <= S_IDLE;
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_q      <= command;
			h_q        <= handle;
			timer_q    <= timer_flag;
			file_q     <= site_file;
			line_q     <= site_line;
			status_q   <= (command != CMD_UNUSED && handle == '0) ? ST_NULL : ST_OK;
			slot_q     <= '0;
			cancel_q   <= 1'b0;
			released_q <= 1'b0;
			ffile_q    <= '0;
			fline_q    <= '0;
		end else if (state_q == S_RSCAN) begin
			if (is_close && r_hit) begin
				status_q <= ST_DUP;
				ffile_q  <= ring_rd_q.file;
				fline_q  <= ring_rd_q.line;
			end
		end else if (state_q == S_SSCAN) begin
			if (is_close) begin
				if (s_match) begin
					slot_q     <= idx_s1[SAW-1:0];
					cancel_q   <= slot_rd_q.timer;
					released_q <= 1'b1;
				end
			end else if (s_free_hit) begin
				slot_q <= idx_s1[SAW-1:0];
			end else if (s_last) begin
				status_q <= ST_FULL;
			end
		end
	end

	assign slot_ext         = {{SLOT_W{1'b0}}, slot_q};
	assign status           = status_q;
	assign slot_index       = slot_ext[SLOT_W-1:0];
	assign cancel_timer     = cancel_q;
	assign released_tracked = released_q;
	assign first_file       = ffile_q;
	assign first_line       = fline_q;

	a_done_single: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done)
		else $error("done held longer than one cycle");

	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> busy)
		else $error("item accepted but block not busy");

	a_cancel_needs_release: assert property (@(posedge clk) disable iff (!arst_n)
		(done && cancel_timer) |-> (released_tracked && status == ST_OK))
		else $error("timer cancel without slot release");

	a_dup_no_release: assert property (@(posedge clk) disable iff (!arst_n)
		(done && status == ST_DUP) |-> (!released_tracked && slot_index == '0))
		else $error("double close released a slot");

	a_hw_bound: assert property (@(posedge clk) disable iff (!arst_n)
		hw_q <= HW'(SLOT_COUNT))
		else $error("slot high-water mark past table size");

endmodule
